>>> rtl/sks_pkg.sv
// ----------------------------------------------------------------------------
// sks_pkg
// Shared types, sizes and the sequencer program of the descending key sorter.
// ----------------------------------------------------------------------------
package sks_pkg;

   localparam int MAX_ITEMS = 64;
   localparam int KEY_W     = 63;
   localparam int IDX_W     = $clog2(MAX_ITEMS);
   localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
   localparam int STEP_W    = 4;
   localparam int IN_TDATA_W  = ((KEY_W + 7) / 8) * 8;
   localparam int OUT_TDATA_W = ((KEY_W + IDX_W + 7) / 8) * 8;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [IDX_W-1:0] idx;
   } entry_type;

   // read address select
   localparam logic [1:0] RD_NONE = 2'd0;
   localparam logic [1:0] RD_I    = 2'd1;
   localparam logic [1:0] RD_I1   = 2'd2;
   localparam logic [1:0] RD_NEXT = 2'd3;

   // write select
   localparam logic [1:0] WR_NONE = 2'd0;
   localparam logic [1:0] WR_LOAD = 2'd1;
   localparam logic [1:0] WR_CUR  = 2'd2;  // current entry to best position
   localparam logic [1:0] WR_BEST = 2'd3;  // best entry to position i

   // branch conditions
   localparam logic [2:0] C_ALWAYS    = 3'd0;
   localparam logic [2:0] C_LOAD_DONE = 3'd1;
   localparam logic [2:0] C_PASS_END  = 3'd2;
   localparam logic [2:0] C_SCAN_MORE = 3'd3;
   localparam logic [2:0] C_OUT_BUSY  = 3'd4;
   localparam logic [2:0] C_EMIT_MORE = 3'd5;

   // program steps
   localparam logic [STEP_W-1:0] S_LOAD      = 4'd0;
   localparam logic [STEP_W-1:0] S_PASS      = 4'd1;
   localparam logic [STEP_W-1:0] S_SEED      = 4'd2;
   localparam logic [STEP_W-1:0] S_SCAN      = 4'd3;
   localparam logic [STEP_W-1:0] S_SWAP_A    = 4'd4;
   localparam logic [STEP_W-1:0] S_SWAP_B    = 4'd5;
   localparam logic [STEP_W-1:0] S_EMIT_INIT = 4'd6;
   localparam logic [STEP_W-1:0] S_EMIT_RD   = 4'd7;
   localparam logic [STEP_W-1:0] S_EMIT_WR   = 4'd8;
   localparam logic [STEP_W-1:0] S_EMIT_NXT  = 4'd9;

   typedef struct packed {
      logic [1:0]        rd_sel;
      logic [1:0]        wr_sel;
      logic              load;     // input ready
      logic              seed;     // best/cur <= read word
      logic              cmp;      // keep strictly greater key
      logic              inc_i;
      logic              clr_i;
      logic              emit;
      logic              clr_cnt;
      logic [2:0]        cond;
      logic [STEP_W-1:0] t_true;
      logic [STEP_W-1:0] t_false;
   } ctl_type;

   function automatic ctl_type ucode(input logic [STEP_W-1:0] step);
      ctl_type w;
      w = '0;
      w.cond = C_ALWAYS;
      w.t_true = S_LOAD;
      w.t_false = S_LOAD;
      case (step)
         S_LOAD: begin
            w.load = 1'b1; w.wr_sel = WR_LOAD; w.clr_i = 1'b1;
            w.cond = C_LOAD_DONE; w.t_true = S_PASS; w.t_false = S_LOAD;
         end
         S_PASS: begin
            w.rd_sel = RD_I;
            w.cond = C_PASS_END; w.t_true = S_EMIT_INIT; w.t_false = S_SEED;
         end
         S_SEED: begin
            w.seed = 1'b1; w.rd_sel = RD_I1;
            w.t_true = S_SCAN;
         end
         S_SCAN: begin
            w.cmp = 1'b1; w.rd_sel = RD_NEXT;
            w.cond = C_SCAN_MORE; w.t_true = S_SCAN; w.t_false = S_SWAP_A;
         end
         S_SWAP_A: begin
            w.wr_sel = WR_CUR; w.t_true = S_SWAP_B;
         end
         S_SWAP_B: begin
            w.wr_sel = WR_BEST; w.inc_i = 1'b1; w.t_true = S_PASS;
         end
         S_EMIT_INIT: begin
            w.clr_i = 1'b1; w.t_true = S_EMIT_RD;
         end
         S_EMIT_RD: begin
            w.rd_sel = RD_I; w.t_true = S_EMIT_WR;
         end
         S_EMIT_WR: begin
            w.emit = 1'b1;
            w.cond = C_OUT_BUSY; w.t_true = S_EMIT_WR; w.t_false = S_EMIT_NXT;
         end
         S_EMIT_NXT: begin
            w.cond = C_EMIT_MORE; w.t_true = S_EMIT_RD; w.t_false = S_LOAD;
            w.clr_cnt = 1'b1;
         end
         default: begin
            w.t_true = S_LOAD;
         end
      endcase
      return w;
   endfunction

endpackage

>>> rtl/sks_store.sv
// ----------------------------------------------------------------------------
// sks_store
// Entry memory: key plus load index, one write and one registered read port.
// ----------------------------------------------------------------------------
module sks_store
   import sks_pkg::*;
(
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  entry_type        wr_data,
   input  logic [IDX_W-1:0] rd_addr,
   output entry_type        rd_data
);

   entry_type mem [MAX_ITEMS];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/sort_keys_descending_with_index_unit.sv
// ----------------------------------------------------------------------------
// sort_keys_descending_with_index_unit
// Loads a list of up to 64 keys, sorts it descending and returns each key
// with the position at which it was loaded.
// ----------------------------------------------------------------------------
// Usage:
//   req_*: one key per word; tlast marks the final key of the list. Keys past
//   the 64th are dropped, but a tlast on them still closes the list.
//   rsp_*: one word per stored key, largest first, with its load index;
//   tlast marks the final word. Equal keys keep selection-sort order.
//   Flow: in the load phase a key is taken whenever req_tvalid is high.
//   After the final key the sorter runs n-1 selection passes on one
//   comparator and one memory read port, then emits the words one at a
//   time, each only once the result register is free or being read.
//   The result register holds a word while rsp_tready is low; the sequencer
//   waits for it. Input is accepted only in the load phase, also while the
//   last result still waits in the result register.
//   Reset (synchronous, active high) empties the list and drops any result.
// ----------------------------------------------------------------------------
module sort_keys_descending_with_index_unit
   import sks_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [IN_TDATA_W-1:0]  req_tdata,   // [62:0] key, rest zero
   input  logic                   req_tlast,   // last_in
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [OUT_TDATA_W-1:0] rsp_tdata,   // [62:0] sorted_key, [68:63] orig_index
   output logic                   rsp_tlast    // last_out
);

   logic [STEP_W-1:0] step_ff, step_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [CNT_W-1:0]  n_ff, n_in;
   logic [CNT_W-1:0]  i_ff, i_in;
   logic [CNT_W-1:0]  rd_addr_ff, rd_addr_in;
   logic [IDX_W-1:0]  bpos_ff, bpos_in;
   entry_type         best_ff, best_in;
   entry_type         cur_ff, cur_in;
   logic              out_valid_ff, out_valid_in;
   entry_type         out_data_ff, out_data_in;
   logic              out_last_ff, out_last_in;

   ctl_type           ctl;
   logic              accept;
   logic              has_room;
   logic              busy;
   logic              cond_hit;
   logic [CNT_W:0]    i_plus1;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   entry_type         wr_data;
   entry_type         rd_data;

   assign ctl      = ucode(step_ff);
   assign accept   = req_tvalid && ctl.load;
   assign has_room = (cnt_ff < CNT_W'(MAX_ITEMS));
   assign busy     = out_valid_ff && !rsp_tready;
   assign i_plus1  = {1'b0, i_ff} + 1'b1;

   always_comb begin
      case (ctl.cond)
         C_ALWAYS:    cond_hit = 1'b1;
         C_LOAD_DONE: cond_hit = accept && req_tlast;
         C_PASS_END:  cond_hit = (i_plus1 >= {1'b0, n_ff});
         C_SCAN_MORE: cond_hit = (({1'b0, rd_addr_ff} + 1'b1) < {1'b0, n_ff});
         C_OUT_BUSY:  cond_hit = busy;
         C_EMIT_MORE: cond_hit = (i_ff < n_ff);
         default:     cond_hit = 1'b1;
      endcase
   end

   assign step_in = cond_hit ? ctl.t_true : ctl.t_false;

   // read address
   always_comb begin
      case (ctl.rd_sel)
         RD_I:    rd_addr_in = i_ff;
         RD_I1:   rd_addr_in = i_plus1[CNT_W-1:0];
         RD_NEXT: rd_addr_in = rd_addr_ff + 1'b1;
         default: rd_addr_in = rd_addr_ff;
      endcase
   end

   // write port
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = i_ff[IDX_W-1:0];
      wr_data = best_ff;
      case (ctl.wr_sel)
         WR_LOAD: begin
            wr_en   = accept && has_room;
            wr_addr = cnt_ff[IDX_W-1:0];
            wr_data = '{key: req_tdata[KEY_W-1:0], idx: cnt_ff[IDX_W-1:0]};
         end
         WR_CUR: begin
            wr_en   = 1'b1;
            wr_addr = bpos_ff;
            wr_data = cur_ff;
         end
         WR_BEST: begin
            wr_en   = 1'b1;
            wr_addr = i_ff[IDX_W-1:0];
            wr_data = best_ff;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   always_comb begin
      cnt_in       = cnt_ff;
      n_in         = n_ff;
      i_in         = i_ff;
      bpos_in      = bpos_ff;
      best_in      = best_ff;
      cur_in       = cur_ff;
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      out_last_in  = out_last_ff;

      if (accept) begin
         if (has_room) begin
            cnt_in = cnt_ff + 1'b1;
         end
         n_in = has_room ? cnt_ff + 1'b1 : cnt_ff;
      end
      if (ctl.clr_cnt) begin
         cnt_in = '0;
      end
      if (ctl.clr_i) begin
         i_in = '0;
      end
      if (ctl.inc_i) begin
         i_in = i_plus1[CNT_W-1:0];
      end
      if (ctl.seed) begin
         best_in = rd_data;
         cur_in  = rd_data;
         bpos_in = i_ff[IDX_W-1:0];
      end
      // only a strictly greater key replaces the best
      if (ctl.cmp && (rd_data.key > best_ff.key)) begin
         best_in = rd_data;
         bpos_in = rd_addr_ff[IDX_W-1:0];
      end

      if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (ctl.emit && !busy) begin
         out_valid_in = 1'b1;
         out_data_in  = rd_data;
         out_last_in  = (i_plus1 == {1'b0, n_ff});
         i_in         = i_plus1[CNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= S_LOAD;
         cnt_ff       <= '0;
         n_ff         <= '0;
         i_ff         <= '0;
         rd_addr_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         cnt_ff       <= cnt_in;
         n_ff         <= n_in;
         i_ff         <= i_in;
         rd_addr_ff   <= rd_addr_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bpos_ff     <= bpos_in;
      best_ff     <= best_in;
      cur_ff      <= cur_in;
      out_data_ff <= out_data_in;
      out_last_ff <= out_last_in;
   end

   sks_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr_in[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   assign req_tready = ctl.load;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = OUT_TDATA_W'({out_data_ff.idx, out_data_ff.key});

endmodule
